[sv/ittd_pkg.sv]
// Package for the integer to decimal text converter.
// Holds widths, character codes, control enums and the control/status structs.
// No dependencies.
`timescale 1ns / 1ps

package ittd_pkg;

	localparam int VALUE_W   = 64;
	localparam int SIZE_W    = 7;
	localparam int CHAR_W    = 8;
	localparam int DIG_W     = 4;
	localparam int MAX_BITS  = 64;
	localparam int NDIG      = 20;
	localparam int CONV_BITS = VALUE_W;
	localparam int CNT_W     = $clog2(CONV_BITS);
	localparam int DCNT_W    = $clog2(NDIG + 1);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_CONV,
		CELL_SHIFT
	} cell_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_SIGN,
		S_SKIP,
		S_EMIT,
		S_ERR
	} state_t;

	typedef enum logic [1:0] {
		OUT_DIGIT,
		OUT_MINUS,
		OUT_ERROR
	} out_kind_t;

	typedef struct packed {
		logic      in_ready;
		logic      load;
		cell_op_t  cell_op;
		logic      wr_out;
		out_kind_t kind;
		logic      last;
	} ctl_t;

	typedef struct packed {
		logic in_fire;
		logic bad;
		logic neg;
		logic top_zero;
		logic slot_free;
	} sts_t;

endpackage

[sv/ittd_if.sv]
// Stream interfaces for the integer to decimal text converter.
// Input beat carries value, bit size and signed flag; output beat one character.
// Depends on ittd_pkg.
`timescale 1ns / 1ps

interface ittd_in_if;
	import ittd_pkg::*;

	logic                valid;
	logic                ready;
	logic [VALUE_W-1:0]  value;
	logic [SIZE_W-1:0]   bit_size;
	logic                is_signed;

	modport source (output valid, output value, output bit_size, output is_signed,
		input ready);
	modport sink (input valid, input value, input bit_size, input is_signed,
		output ready);
endinterface

interface ittd_out_if;
	import ittd_pkg::*;

	logic               valid;
	logic               ready;
	logic [CHAR_W-1:0]  text_char;
	logic               last_char;
	logic               bad_size;

	modport source (output valid, output text_char, output last_char, output bad_size,
		input ready);
	modport sink (input valid, input text_char, input last_char, input bad_size,
		output ready);
endinterface

[sv/ittd_cell.sv]
// One BCD digit cell of the conversion chain.
// Shifts in a bit with add-3 correction, or takes its lower neighbor's digit.
// Depends on ittd_pkg.
`timescale 1ns / 1ps

module ittd_cell (
	input  logic                          clk,
	input  ittd_pkg::cell_op_t            op,
	input  logic                          bit_in,
	input  logic [ittd_pkg::DIG_W-1:0]    dig_in,
	output logic [ittd_pkg::DIG_W-1:0]    dig,
	output logic                          carry_out
);
	import ittd_pkg::*;

	logic [DIG_W-1:0] dig_q;
	logic [DIG_W-1:0] adj;

	// correct digits of five and up before the doubling shift
	always_comb begin
		adj = (dig_q >= DIG_W'(5)) ? dig_q + DIG_W'(3) : dig_q;
	end

	assign carry_out = adj[DIG_W-1];
	assign dig       = dig_q;

	// clear, double-and-insert, or take the neighbor's digit
	always_ff @(posedge clk) begin
		case (op)
			CELL_CLEAR: dig_q <= '0;
			CELL_CONV:  dig_q <= {adj[DIG_W-2:0], bit_in};
			CELL_SHIFT: dig_q <= dig_in;
			default:    dig_q <= dig_q;
		endcase
	end

endmodule

[sv/ittd_ctrl.sv]
// Sequencer for the converter: conversion count, leading-zero skip and emit.
// Drives the digit chain and the output register through a ctl_t struct.
// Depends on ittd_pkg.
`timescale 1ns / 1ps

module ittd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  ittd_pkg::sts_t  sts,
	output ittd_pkg::ctl_t  ctl
);
	import ittd_pkg::*;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic [DCNT_W-1:0]  dcnt_q;
	logic               more_digits;

	assign more_digits = dcnt_q > DCNT_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (sts.in_fire) state_d = sts.bad ? S_ERR : S_CONV;
			end
			S_CONV: begin
				if (cnt_q == CNT_W'(CONV_BITS - 1)) state_d = S_SIGN;
			end
			S_SIGN: begin
				if (!sts.neg || sts.slot_free) state_d = S_SKIP;
			end
			S_SKIP: begin
				if (!(sts.top_zero && more_digits)) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.slot_free && !more_digits) state_d = S_IDLE;
			end
			S_ERR: begin
				if (sts.slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl = '{in_ready: 1'b0, load: 1'b0, cell_op: CELL_HOLD, wr_out: 1'b0,
			kind: OUT_DIGIT, last: 1'b0};
		case (state_q)
			S_IDLE: begin
				ctl.in_ready = 1'b1;
				if (sts.in_fire && !sts.bad) begin
					ctl.load    = 1'b1;
					ctl.cell_op = CELL_CLEAR;
				end
			end
			S_CONV: begin
				ctl.cell_op = CELL_CONV;
			end
			S_SIGN: begin
				if (sts.neg && sts.slot_free) begin
					ctl.wr_out = 1'b1;
					ctl.kind   = OUT_MINUS;
				end
			end
			S_SKIP: begin
				if (sts.top_zero && more_digits) ctl.cell_op = CELL_SHIFT;
			end
			S_EMIT: begin
				if (sts.slot_free) begin
					ctl.wr_out  = 1'b1;
					ctl.kind    = OUT_DIGIT;
					ctl.last    = !more_digits;
					ctl.cell_op = CELL_SHIFT;
				end
			end
			S_ERR: begin
				if (sts.slot_free) begin
					ctl.wr_out = 1'b1;
					ctl.kind   = OUT_ERROR;
					ctl.last   = 1'b1;
				end
			end
			default: ctl.in_ready = 1'b0;
		endcase
	end

	// state, bit count and remaining digit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			dcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CONV) cnt_q <= cnt_q + CNT_W'(1);
			else cnt_q <= '0;
			if (ctl.load) dcnt_q <= DCNT_W'(NDIG);
			else if (ctl.cell_op == CELL_SHIFT) dcnt_q <= dcnt_q - DCNT_W'(1);
		end
	end

	a_wr_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_out |-> sts.slot_free)
		else $error("output written while slot occupied");

	a_emit_has_digit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> dcnt_q != '0)
		else $error("emit with no digits left");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_out && ctl.last |=> state_q == S_IDLE)
		else $error("final beat did not return to idle");

endmodule

[sv/integer_to_decimal_text.sv]
// Integer to decimal ASCII text: a 64-step double-dabble over a row of 20 BCD cells.
// Each item passes through accept, the bit conversion loop, an optional minus sign, then
// leading-zero skip and emit (one character per cycle while the output is not stalled).
// A bad size skips conversion and answers with a single error beat marked last.
// One item at a time: a new input is taken only after its last character is written out.
// arst_n clears the sequencer and the output valid; digit cells are cleared on load.
`timescale 1ns / 1ps

module integer_to_decimal_text (
	input  logic         clk,
	input  logic         arst_n,
	ittd_in_if.sink      din,
	ittd_out_if.source   dout
);
	import ittd_pkg::*;

	ctl_t                ctl;
	sts_t                sts;
	logic [VALUE_W-1:0]  bin_q;
	logic                neg_q;
	logic [SIZE_W-1:0]   sh;
	logic [VALUE_W-1:0]  ext;
	logic [VALUE_W-1:0]  mag;
	logic                neg;
	logic                bad;
	logic [DIG_W-1:0]    dig   [NDIG];
	logic                carry [NDIG+1];
	logic [DIG_W-1:0]    top_dig;
	logic                out_valid_q;
	logic [CHAR_W-1:0]   char_q;
	logic                last_q;
	logic                bad_q;

	// size check and sign extension of the incoming beat
	assign bad = (din.bit_size == '0) || (din.bit_size > SIZE_W'(MAX_BITS))
		|| (din.bit_size[2:0] != 3'd0);
	assign sh  = SIZE_W'(VALUE_W) - din.bit_size;
	assign ext = VALUE_W'($signed(din.value << sh) >>> sh);
	assign neg = din.is_signed && ext[VALUE_W-1];
	assign mag = neg ? (~ext + VALUE_W'(1)) : (din.is_signed ? ext : din.value);

	// hold magnitude; feed its top bit into the cell row each conversion step
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			bin_q <= mag;
			neg_q <= neg;
		end else if (ctl.cell_op == CELL_CONV) begin
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
		end
	end

	// row of BCD cells, least significant digit at index zero
	assign carry[0] = bin_q[VALUE_W-1];
	for (genvar i = 0; i < NDIG; i++) begin : g_cell
		ittd_cell u_cell (
			.clk       (clk),
			.op        (ctl.cell_op),
			.bit_in    (carry[i]),
			.dig_in    ((i == 0) ? DIG_W'(0) : dig[(i == 0) ? 0 : i-1]),
			.dig       (dig[i]),
			.carry_out (carry[i+1])
		);
	end
	assign top_dig = dig[NDIG-1];

	// status to the sequencer
	assign sts.in_fire   = din.valid && ctl.in_ready;
	assign sts.bad       = bad;
	assign sts.neg       = neg_q;
	assign sts.top_zero  = top_dig == '0;
	assign sts.slot_free = !out_valid_q || dout.ready;

	ittd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	assign din.ready = ctl.in_ready;

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.wr_out) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_out) begin
			case (ctl.kind)
				OUT_DIGIT: char_q <= CHAR_ZERO + {{(CHAR_W-DIG_W){1'b0}}, top_dig};
				OUT_MINUS: char_q <= CHAR_MINUS;
				default:   char_q <= CHAR_NONE;
			endcase
			last_q <= ctl.last;
			bad_q  <= ctl.kind == OUT_ERROR;
		end
	end

	assign dout.valid     = out_valid_q;
	assign dout.text_char = char_q;
	assign dout.last_char = last_q;
	assign dout.bad_size  = bad_q;

	a_no_top_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cell_op == CELL_CONV |-> !carry[NDIG])
		else $error("carry out of the top digit cell");

	a_digit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_out && ctl.kind == OUT_DIGIT |-> top_dig <= DIG_W'(9))
		else $error("emitted digit above nine");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_out && ctl.kind == OUT_ERROR |-> ctl.last)
		else $error("error beat not marked final");

endmodule
